[hdl/bdsd_pkg.sv]
// ---------------------------------------------------------------------------
// bdsd_pkg
// Shared widths, reset values, register codes and lane status type for the
// button debouncer with stuck-button detection.
// ---------------------------------------------------------------------------
package bdsd_pkg;

   // default sizing
   localparam int NUM_BUTTONS_DEF = 4;
   localparam int TIME_BITS_DEF   = 32;

   // field widths
   localparam int NOW_BITS       = 32;
   localparam int RAW_BITS       = 4;
   localparam int ACTION_BITS    = 3;
   localparam int WARN_BITS      = 4;
   localparam int CFG_BITS       = 16;
   localparam int REQ_TDATA_BITS = 40;
   localparam int RSP_TDATA_BITS = 8;
   localparam int CSR_INDEX_BITS = 1;

   // register reset values
   localparam logic [CFG_BITS-1:0] DEBOUNCE_MS_RESET = 16'd35;
   localparam logic [CFG_BITS-1:0] STUCK_MS_RESET    = 16'd2000;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEBOUNCE_MS = 1'b0,
      CSR_STUCK_MS    = 1'b1
   } csr_index_type;

   // action codes
   localparam logic [ACTION_BITS-1:0] ACT_NONE = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_BACK = 3'd4;

   // per-button result of one poll
   typedef struct packed {
      logic press;   // stable level newly went low
      logic warn;    // stuck warning fired
   } lane_status_type;

endpackage

[hdl/bdsd_lane.sv]
// ---------------------------------------------------------------------------
// bdsd_lane
// One button: raw change tracking, settle timer, stable level, and the
// stuck-hold timer with repeating warnings. State advances only on step.
// ---------------------------------------------------------------------------
module bdsd_lane #(
   parameter int TIME_BITS = bdsd_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [TIME_BITS-1:0]           now,
   input  logic                           level,
   input  logic [bdsd_pkg::CFG_BITS-1:0]  debounce_ms,
   input  logic [bdsd_pkg::CFG_BITS-1:0]  stuck_ms,
   output bdsd_pkg::lane_status_type      status
);

   logic                 last_raw_ff,    last_raw_in;
   logic                 stable_ff,      stable_in;
   logic [TIME_BITS-1:0] change_time_ff, change_time_in;
   logic [TIME_BITS-1:0] held_since_ff,  held_since_in;
   logic [TIME_BITS-1:0] last_warn_ff,   last_warn_in;

   logic [TIME_BITS-1:0] held_use;
   logic [TIME_BITS-1:0] settle_age;
   logic [TIME_BITS-1:0] held_age;
   logic [TIME_BITS-1:0] warn_age;
   logic [TIME_BITS-1:0] debounce_t;
   logic [TIME_BITS-1:0] stuck_t;
   logic                 settle;
   logic                 press;
   logic                 fire;

   assign debounce_t = TIME_BITS'(debounce_ms);
   assign stuck_t    = TIME_BITS'(stuck_ms);

   // restart settle timer on a raw change
   assign last_raw_in    = level;
   assign change_time_in = (level != last_raw_ff) ? now : change_time_ff;
   assign settle_age     = now - change_time_in;
   assign settle         = (settle_age >= debounce_t) && (stable_ff != level);

   // hold timer ages
   assign held_use = (held_since_ff == '0) ? now : held_since_ff;
   assign held_age = now - held_use;
   assign warn_age = now - last_warn_ff;

   // stable level, press and stuck warning
   always_comb begin
      stable_in     = stable_ff;
      held_since_in = held_since_ff;
      last_warn_in  = last_warn_ff;
      press         = 1'b0;
      fire          = 1'b0;
      if (settle) begin
         stable_in     = level;
         held_since_in = '0;
         last_warn_in  = '0;
         if (!level) begin
            held_since_in = now;
            press         = 1'b1;
         end
      end
      if (!press) begin
         if (!stable_in) begin
            // held low with no new transition this poll
            held_since_in = held_use;
            fire = (held_age >= stuck_t) &&
                   ((last_warn_ff == '0) || (warn_age >= stuck_t));
            if (fire) begin
               last_warn_in = now;
            end
         end else begin
            held_since_in = '0;
            last_warn_in  = '0;
         end
      end
   end

   assign status.press = press;
   assign status.warn  = fire;

   // advance lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= 1'b1;
         stable_ff      <= 1'b1;
         change_time_ff <= '0;
         held_since_ff  <= '0;
         last_warn_ff   <= '0;
      end else if (step) begin
         last_raw_ff    <= last_raw_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
         held_since_ff  <= held_since_in;
         last_warn_ff   <= last_warn_in;
      end
   end

endmodule

[hdl/button_debounce_stuck_detect_unit.sv]
// ---------------------------------------------------------------------------
// button_debounce_stuck_detect_unit
// Debouncer for active-low buttons (up, down, select, back) with stuck-button
// warnings. Each request transfer is one poll; each poll yields one response.
// ---------------------------------------------------------------------------
//  channel  direction  payload
//  req      in         tdata: now_ms[31:0], raw_levels[35:32], zero pad
//  rsp      out        tdata: pressed_action[2:0], stuck_warn[6:3], zero pad
//  csr      in         index 0 debounce_ms, index 1 stuck_ms (16 bit)
//
//  One poll per cycle sustained while the response is not stalled; a poll
//  passes the input register, then the button lanes feeding the response register.
//  The lane state loop is combinational: subtract-and-compare per button
//  and a priority cut-off across the buttons.
//  A stalled response holds the pipeline; the input register still takes a
//  transfer while the response register is drained in the same cycle.
//  Synchronous active-high reset releases all buttons and loads the register
//  defaults.
// ---------------------------------------------------------------------------
module button_debounce_stuck_detect_unit #(
   parameter int NUM_BUTTONS = bdsd_pkg::NUM_BUTTONS_DEF,
   parameter int TIME_BITS   = bdsd_pkg::TIME_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // poll input
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bdsd_pkg::REQ_TDATA_BITS-1:0]   req_tdata,  // now_ms, raw_levels
   // poll result
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bdsd_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,  // pressed_action, stuck_warn
   // register writes
   input  logic                                  csr_we,
   input  logic [bdsd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bdsd_pkg::CFG_BITS-1:0]         csr_wdata
);

   localparam int ACTION_BITS = bdsd_pkg::ACTION_BITS;
   localparam int WARN_BITS   = bdsd_pkg::WARN_BITS;
   localparam int RAW_BITS    = bdsd_pkg::RAW_BITS;

   logic [bdsd_pkg::CFG_BITS-1:0] debounce_ms_ff;
   logic [bdsd_pkg::CFG_BITS-1:0] stuck_ms_ff;

   logic                  in_valid_ff;
   logic [TIME_BITS-1:0]  in_now_ff;
   logic [RAW_BITS-1:0]   in_raw_ff;

   logic                  rsp_valid_ff;
   logic [ACTION_BITS-1:0] rsp_action_ff, rsp_action_in;
   logic [WARN_BITS-1:0]  rsp_warn_ff,   rsp_warn_in;

   logic                  advance;
   logic [NUM_BUTTONS:0]  skip;
   bdsd_pkg::lane_status_type lane_status [NUM_BUTTONS];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= bdsd_pkg::DEBOUNCE_MS_RESET;
         stuck_ms_ff    <= bdsd_pkg::STUCK_MS_RESET;
      end else if (csr_we) begin
         unique case (bdsd_pkg::csr_index_type'(csr_index))
            bdsd_pkg::CSR_DEBOUNCE_MS: debounce_ms_ff <= csr_wdata;
            bdsd_pkg::CSR_STUCK_MS:    stuck_ms_ff    <= csr_wdata;
            default:                   ;
         endcase
      end
   end

   // handshake: process when the response register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_now_ff <= req_tdata[TIME_BITS-1:0];
         in_raw_ff <= req_tdata[bdsd_pkg::NOW_BITS +: RAW_BITS];
      end
   end

   // button lanes; a press stops the later buttons for this poll
   assign skip[0] = 1'b0;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      logic level;
      if (i < RAW_BITS) begin : g_pin
         assign level = in_raw_ff[i];
      end else begin : g_idle
         assign level = 1'b1;
      end

      bdsd_lane #(
         .TIME_BITS (TIME_BITS)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .step        (advance && !skip[i]),
         .now         (in_now_ff),
         .level       (level),
         .debounce_ms (debounce_ms_ff),
         .stuck_ms    (stuck_ms_ff),
         .status      (lane_status[i])
      );

      assign skip[i+1] = skip[i] || lane_status[i].press;
   end

   // collect action and warnings
   always_comb begin
      rsp_action_in = bdsd_pkg::ACT_NONE;
      rsp_warn_in   = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (!skip[i] && lane_status[i].press) begin
            rsp_action_in = ACTION_BITS'(i + 1);
         end
         if (i < WARN_BITS) begin
            if (!skip[i] && lane_status[i].warn) begin
               rsp_warn_in[i] = 1'b1;
            end
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_action_ff <= rsp_action_in;
         rsp_warn_ff   <= rsp_warn_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_warn_ff, rsp_action_ff};

`ifndef SYNTHESIS
   // action code stays within the button list
   a_action_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_action_ff <= bdsd_pkg::ACT_BACK))
      else $error("pressed_action out of range");

   // no warning from the pressing button or any button after it
   a_warn_cutoff: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_action_ff != bdsd_pkg::ACT_NONE)) |->
      ((rsp_warn_ff >> (rsp_action_ff - 3'd1)) == '0))
      else $error("stuck warning past the pressed button");

   // a processed poll always lands in the response register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed poll lost");

   // a poll waiting on a stalled response is kept
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_now_ff)))
      else $error("waiting poll dropped");
`endif

endmodule
